// ===== rtl/clle_pkg.sv =====
`timescale 1ns / 1ps

package clle_pkg;

    // Number of data slots; slot 0 is the list head.
    localparam int SLOTS      = 16;
    localparam int LINK_DEPTH = SLOTS + 1;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    // Field widths of the transactions.
    localparam int POS_W    = 5;
    localparam int SLOT_W   = 5;
    localparam int LEN_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_BEYOND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_WAIT,
        S_INS_NODE,
        S_INS_PRED,
        S_DEL_PRED,
        S_DEL_NODE,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/clle_if.sv =====
`timescale 1ns / 1ps

// Request channel: one list operation per transaction.
interface clle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic        [clle_pkg::POS_W-1:0]    position;
    logic signed [clle_pkg::VALUE_W-1:0]  item_value;

    modport source (output valid, kind, position, item_value, input ready);
    modport sink   (input valid, kind, position, item_value, output ready);
endinterface

// Result channel: one result per operation.
interface clle_out_if;
    logic                              valid;
    logic                              ready;
    logic [clle_pkg::STATUS_W-1:0]     status;
    logic [clle_pkg::SLOT_W-1:0]       slot;
    logic [clle_pkg::LEN_W-1:0]        list_length;

    modport source (output valid, status, slot, list_length, input ready);
    modport sink   (input valid, status, slot, list_length, output ready);
endinterface

// ===== rtl/cursor_linked_list_engine_unit.sv =====
`timescale 1ns / 1ps

// Cursor (array-backed) singly linked list engine.
// Each transaction on i_in is one operation: insert item_value so that it
// becomes the node at a 1-based position, or delete the node at a position.
// Each operation produces exactly one transaction on o_out with a status
// (ok, full, illegal position, beyond length), the slot that was filled or
// freed (0 on failure) and the list length after the operation.
// Operations are handled one at a time. A failed operation goes straight to
// the finishing state without a walk. A successful one walks the links one slot per
// cycle through the link memory while the lowest free slot is searched in
// parallel, one flag per cycle; an insert then waits for that search to end.
// The result sits in an output register, so i_in is ready again as soon as
// the operation is finished even if o_out is stalled; a second finished
// result waits inside the engine until the output register is taken.
// Synchronous reset empties the list: the head links to the end, all data
// slots are free and the length is zero. Link entries are cleared at once
// through per-entry valid bits, so no clearing pass is needed.
module cursor_linked_list_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clle_in_if.sink     i_in,
    clle_out_if.source  o_out
);

    import clle_pkg::*;

    localparam logic [POS_W-1:0]   SLOTS_POS  = POS_W'(SLOTS);
    localparam logic [LINK_AW-1:0] SLOTS_LINK = LINK_AW'(SLOTS);
    localparam logic [LEN_W-1:0]   SLOTS_LEN  = LEN_W'(SLOTS);

    // Control state.
    t_state               r_state, n_state;
    logic                 r_out_valid;
    logic [LEN_W-1:0]     r_count;
    logic                 r_free     [0:SLOTS];
    logic                 r_link_vld [0:SLOTS];
    logic                 r_rd_vld;
    logic                 r_scan_done;

    // Operation context.
    t_kind                r_kind;
    logic [VALUE_W-1:0]   r_value;
    logic [POS_W-1:0]     r_steps;
    logic [LINK_AW-1:0]   r_cur;
    logic [LINK_AW-1:0]   r_pred_next;
    logic [LINK_AW-1:0]   r_scan;
    logic [LINK_AW-1:0]   r_found;
    t_status              r_status;
    logic [SLOT_W-1:0]    r_slot;

    // Output register.
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [LEN_W-1:0]     r_out_len;

    // Memory ports.
    logic [LINK_AW-1:0]   link_rd_addr;
    logic [LINK_AW-1:0]   link_rd_raw;
    logic [LINK_AW-1:0]   link_data;
    logic                 link_wr_en;
    logic [LINK_AW-1:0]   link_wr_addr;
    logic [LINK_AW-1:0]   link_wr_data;
    logic                 value_wr_en;

    logic                 in_accept;
    logic                 out_free;
    logic                 link_end;
    logic                 walk_done;
    logic                 pos_illegal;
    logic                 ins_beyond;
    logic                 del_beyond;
    t_status              accept_status;

    clle_ram #(
        .WIDTH (LINK_AW),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_raw)
    );

    // Node values are stored for completeness of the list state; no
    // operation result depends on them.
    clle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LINK_DEPTH)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (value_wr_en),
        .i_wr_addr (r_found),
        .i_wr_data (r_value),
        .i_rd_addr (r_found),
        .o_rd_data ()
    );

    // A link entry never written since reset reads as the end marker.
    assign link_data = r_rd_vld ? link_rd_raw : '0;
    assign link_end  = (link_data == '0) || (link_data > SLOTS_LINK);
    assign walk_done = (r_steps == '0) || link_end;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    assign pos_illegal = (i_in.position == '0) || (i_in.position > SLOTS_POS);
    assign ins_beyond  = {1'b0, i_in.position} > ({1'b0, r_count} + (LEN_W + 1)'(1));
    assign del_beyond  = {1'b0, i_in.position} > {1'b0, r_count};

    // Status decided at acceptance; ST_OK means the walk is started.
    always_comb begin
        accept_status = ST_OK;
        if (t_kind'(i_in.kind) == KIND_INSERT) begin
            if (r_count == SLOTS_LEN) begin
                accept_status = ST_FULL;
            end else if (pos_illegal) begin
                accept_status = ST_ILLEGAL;
            end else if (ins_beyond) begin
                accept_status = ST_BEYOND;
            end
        end else begin
            if (pos_illegal) begin
                accept_status = ST_ILLEGAL;
            end else if (del_beyond) begin
                accept_status = ST_BEYOND;
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (accept_status == ST_OK) ? S_WALK : S_FINISH;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    if (r_kind == KIND_INSERT) begin
                        n_state = S_INS_WAIT;
                    end else begin
                        n_state = link_end ? S_FINISH : S_DEL_PRED;
                    end
                end
            end
            S_INS_WAIT: begin
                if (r_scan_done) begin
                    n_state = S_INS_NODE;
                end
            end
            S_INS_NODE: n_state = S_INS_PRED;
            S_INS_PRED: n_state = S_FINISH;
            S_DEL_PRED: n_state = S_DEL_NODE;
            S_DEL_NODE: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory and handshake controls.
    always_comb begin
        i_in.ready   = 1'b0;
        link_rd_addr = r_cur;
        link_wr_en   = 1'b0;
        link_wr_addr = r_cur;
        link_wr_data = '0;
        value_wr_en  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready   = 1'b1;
                link_rd_addr = '0;
            end
            S_WALK: begin
                if (!walk_done) begin
                    link_rd_addr = link_data;
                end else if (r_kind == KIND_DELETE && !link_end) begin
                    // Fetch the successor of the node being removed.
                    link_rd_addr = link_data;
                end
            end
            S_INS_NODE: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_found;
                link_wr_data = r_pred_next;
                value_wr_en  = 1'b1;
            end
            S_INS_PRED: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_cur;
                link_wr_data = r_found;
            end
            S_DEL_PRED: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_cur;
                link_wr_data = link_data;
            end
            S_DEL_NODE: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_pred_next;
                link_wr_data = '0;
            end
            S_INS_WAIT, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.slot        = r_out_slot;
    assign o_out.list_length = r_out_len;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_scan_done <= 1'b0;
            for (int i = 0; i <= SLOTS; i++) begin
                r_free[i]     <= (i != 0);
                r_link_vld[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_link_vld[link_rd_addr];

            if (link_wr_en) begin
                r_link_vld[link_wr_addr] <= 1'b1;
            end

            if (in_accept) begin
                r_scan_done <= 1'b0;
            end else if (r_state != S_IDLE && !r_scan_done) begin
                if (r_free[r_scan] || r_scan == SLOTS_LINK) begin
                    r_scan_done <= 1'b1;
                end
            end

            if (r_state == S_INS_PRED) begin
                r_free[r_found] <= 1'b0;
                r_count         <= r_count + LEN_W'(1);
            end
            if (r_state == S_DEL_NODE) begin
                r_free[r_pred_next] <= 1'b1;
                if (r_count != '0) begin
                    r_count <= r_count - LEN_W'(1);
                end
            end

            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation context and output payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind   <= t_kind'(i_in.kind);
            r_value  <= i_in.item_value;
            r_steps  <= i_in.position - POS_W'(1);
            r_cur    <= '0;
            r_scan   <= LINK_AW'(1);
            r_status <= accept_status;
            r_slot   <= '0;
        end else begin
            if (r_state != S_IDLE && !r_scan_done) begin
                if (r_free[r_scan]) begin
                    r_found <= r_scan;
                end else if (r_scan != SLOTS_LINK) begin
                    r_scan <= r_scan + LINK_AW'(1);
                end
            end
            if (r_state == S_WALK) begin
                if (!walk_done) begin
                    r_cur   <= link_data;
                    r_steps <= r_steps - POS_W'(1);
                end else begin
                    r_pred_next <= link_data;
                    if (r_kind == KIND_DELETE && link_end) begin
                        r_status <= ST_BEYOND;
                    end
                end
            end
            if (r_state == S_INS_PRED) begin
                r_slot <= SLOT_W'(r_found);
            end
            if (r_state == S_DEL_NODE) begin
                r_slot <= SLOT_W'(r_pred_next);
            end
        end

        if (r_state == S_FINISH && out_free) begin
            r_out_status <= r_status;
            r_out_slot   <= r_slot;
            r_out_len    <= r_count;
        end
    end

endmodule

// ===== rtl/clle_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and a registered read port.
module clle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== dv/clle_list_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels. Every accepted request runs through a behavioral
// copy of the list, and the predicted result is compared field by field when
// the result transaction is taken.
module clle_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    clle_in_if   i_req,
    clle_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_model_length,
    output int   o_ok_count,
    output int   o_full_count,
    output int   o_illegal_count,
    output int   o_beyond_count
);

    import clle_pkg::*;

    localparam int EXP_DEPTH = 64;

    // Behavioral list state.
    int   r_link [0:SLOTS];
    bit   r_free [0:SLOTS];
    int   r_count = 0;

    // Predicted results in request order.
    int   r_exp_status [0:EXP_DEPTH-1];
    int   r_exp_slot   [0:EXP_DEPTH-1];
    int   r_exp_len    [0:EXP_DEPTH-1];
    int   r_wr_ptr = 0;
    int   r_rd_ptr = 0;
    int   r_fails  = 0;
    int   r_status_seen [0:3];

    // Result payload held while the receiver stalls.
    logic                r_rsp_hold = 1'b0;
    logic [STATUS_W-1:0] r_hold_status;
    logic [SLOT_W-1:0]   r_hold_slot;
    logic [LEN_W-1:0]    r_hold_len;

    int   st;
    int   sl;
    int   idx;

    assign o_fail_count    = r_fails;
    assign o_pending       = r_wr_ptr - r_rd_ptr;
    assign o_model_length  = r_count;
    assign o_ok_count      = r_status_seen[0];
    assign o_full_count    = r_status_seen[1];
    assign o_illegal_count = r_status_seen[2];
    assign o_beyond_count  = r_status_seen[3];

    initial begin
        for (int i = 0; i < 4; i++) begin
            r_status_seen[i] = 0;
        end
    end

    // Slot of the node at a 1-based position; position zero is the head.
    function automatic int walk_to(input int pos);
        int cur;
        int nx;
        int i;
        cur = 0;
        for (i = 0; i < pos && i < SLOTS; i++) begin
            nx = r_link[cur];
            if (nx == 0 || nx > SLOTS) begin
                break;
            end
            cur = nx;
        end
        return cur;
    endfunction

    function automatic void model_step(input int kind, input int pos,
                                       output int status, output int slot);
        int fs;
        int pred;
        int victim;
        int i;
        status = int'(ST_OK);
        slot   = 0;
        if (kind == int'(KIND_INSERT)) begin
            fs = 0;
            for (i = SLOTS; i >= 1; i--) begin
                if (r_free[i]) begin
                    fs = i;
                end
            end
            if (fs == 0) begin
                status = int'(ST_FULL);
            end else if (pos < 1 || pos > SLOTS) begin
                status = int'(ST_ILLEGAL);
            end else if (pos > r_count + 1) begin
                status = int'(ST_BEYOND);
            end else begin
                pred       = walk_to(pos - 1);
                r_link[fs] = r_link[pred];
                r_link[pred] = fs;
                r_free[fs] = 1'b0;
                r_count    = r_count + 1;
                slot       = fs;
            end
        end else begin
            if (pos < 1 || pos > SLOTS) begin
                status = int'(ST_ILLEGAL);
            end else if (pos > r_count) begin
                status = int'(ST_BEYOND);
            end else begin
                pred   = walk_to(pos - 1);
                victim = r_link[pred];
                if (victim == 0 || victim > SLOTS) begin
                    status = int'(ST_BEYOND);
                end else begin
                    r_link[pred]   = r_link[victim];
                    r_link[victim] = 0;
                    r_free[victim] = 1'b1;
                    if (r_count > 0) begin
                        r_count = r_count - 1;
                    end
                    slot = victim;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SLOTS; i++) begin
                r_link[i] = 0;
                r_free[i] = (i != 0);
            end
            r_count    = 0;
            r_wr_ptr   = 0;
            r_rd_ptr   = 0;
            r_rsp_hold = 1'b0;
        end else begin
            // A stalled result must keep its valid and its payload.
            if (r_rsp_hold) begin
                if (!i_rsp.valid) begin
                    $error("result valid dropped while the receiver stalled");
                    r_fails = r_fails + 1;
                end else if (i_rsp.status != r_hold_status || i_rsp.slot != r_hold_slot ||
                             i_rsp.list_length != r_hold_len) begin
                    $error("result payload changed while the receiver stalled");
                    r_fails = r_fails + 1;
                end
            end
            r_rsp_hold    = i_rsp.valid && !i_rsp.ready;
            r_hold_status = i_rsp.status;
            r_hold_slot   = i_rsp.slot;
            r_hold_len    = i_rsp.list_length;

            if (i_rsp.valid && i_rsp.ready) begin
                if (r_wr_ptr == r_rd_ptr) begin
                    $error("result transaction with no request outstanding");
                    r_fails = r_fails + 1;
                end else begin
                    idx = r_rd_ptr % EXP_DEPTH;
                    if (int'(i_rsp.status) != r_exp_status[idx]) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               r_exp_status[idx], i_rsp.status);
                        r_fails = r_fails + 1;
                    end
                    if (int'(i_rsp.slot) != r_exp_slot[idx]) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               r_exp_slot[idx], i_rsp.slot);
                        r_fails = r_fails + 1;
                    end
                    if (int'(i_rsp.list_length) != r_exp_len[idx]) begin
                        $error("list_length mismatch: expected %0d, actual %0d",
                               r_exp_len[idx], i_rsp.list_length);
                        r_fails = r_fails + 1;
                    end
                    r_status_seen[int'(i_rsp.status)] = r_status_seen[int'(i_rsp.status)] + 1;
                    r_rd_ptr = r_rd_ptr + 1;
                end
            end

            if (i_req.valid && i_req.ready) begin
                model_step(int'(i_req.kind), int'(i_req.position), st, sl);
                idx = r_wr_ptr % EXP_DEPTH;
                r_exp_status[idx] = st;
                r_exp_slot[idx]   = sl;
                r_exp_len[idx]    = r_count;
                r_wr_ptr = r_wr_ptr + 1;
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import clle_pkg::*;

    localparam int N_ITEMS     = 1950;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    clle_in_if  in_if ();
    clle_out_if out_if ();

    int fail_count;
    int pending;
    int model_length;
    int ok_count;
    int full_count;
    int illegal_count;
    int beyond_count;

    int          phase = 0;
    int          sent;
    int          n_insert = 0;
    int          n_delete = 0;
    int          cycles = 0;
    int          tx_idle;
    int          roll;
    int          hi;
    int          pos_sel;
    int          value_roll;
    logic        fill;
    t_kind       kind_sel;
    logic [31:0] value_sel;

    cursor_linked_list_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    clle_list_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (in_if),
        .i_rsp           (out_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_model_length  (model_length),
        .o_ok_count      (ok_count),
        .o_full_count    (full_count),
        .o_illegal_count (illegal_count),
        .o_beyond_count  (beyond_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // The run is cut off far above what a correct run needs.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d results outstanding", pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random idling, plus two long stalls counted in its own cycles.
    initial begin : rx
        int rx_cycle;
        int hold;
        int rx_idle;
        rx_cycle = 0;
        hold     = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle = rx_cycle + 1;
            if (rx_cycle == 2000 || rx_cycle == 9000) begin
                hold = 240;
            end
            rx_idle = (phase == 0) ? 58 : (phase == 1) ? 22 : 0;
            if (hold > 0) begin
                out_if.ready = 1'b0;
                hold = hold - 1;
            end else begin
                out_if.ready = ($urandom_range(0, 99) >= rx_idle) ? 1'b1 : 1'b0;
            end
        end
    end

    // Sender: stimulus, drain pauses and the verdict.
    initial begin : tx
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_INSERT;
        in_if.position   = '0;
        in_if.item_value = '0;
        i_rst_n          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (sent = 0; sent < N_ITEMS; sent++) begin
            phase   = (sent < 650) ? 0 : (sent < 1300) ? 1 : 2;
            tx_idle = (phase == 0) ? 22 : (phase == 1) ? 58 : 0;

            // Now and then let every outstanding result come back first.
            if (sent % 250 == 125) begin
                in_if.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            while ($urandom_range(0, 99) < tx_idle) begin
                in_if.valid = 1'b0;
                @(negedge i_clk);
            end

            // Alternate between filling and draining the list.
            fill     = ((sent / 150) % 2) == 0;
            kind_sel = ($urandom_range(0, 99) < (fill ? 80 : 25)) ? KIND_INSERT : KIND_DELETE;
            roll     = $urandom_range(0, 99);
            if (roll < 3) begin
                pos_sel = 0;
            end else if (roll < 7) begin
                pos_sel = $urandom_range(SLOTS + 1, 31);
            end else if (roll < 14) begin
                pos_sel = $urandom_range(1, SLOTS);
            end else begin
                hi = (kind_sel == KIND_INSERT) ? model_length + 1 : model_length;
                if (hi > SLOTS) begin
                    hi = SLOTS;
                end
                if (hi < 1) begin
                    hi = 1;
                end
                pos_sel = $urandom_range(1, hi);
            end
            value_roll = $urandom_range(0, 9);
            value_sel  = (value_roll == 0) ? 32'h8000_0000 :
                         (value_roll == 1) ? 32'h7fff_ffff : $urandom;

            if (kind_sel == KIND_INSERT) begin
                n_insert = n_insert + 1;
            end else begin
                n_delete = n_delete + 1;
            end

            in_if.kind       = kind_sel;
            in_if.position   = POS_W'(pos_sel);
            in_if.item_value = value_sel;
            in_if.valid      = 1'b1;
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        in_if.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);

        $display("Ran %0d operations (%0d inserts, %0d deletes) under three idle patterns,",
                 N_ITEMS, n_insert, n_delete);
        $display("long receiver stalls and drain pauses; statuses ok %0d, full %0d, %s %0d, %s %0d.",
                 ok_count, full_count, "illegal", illegal_count, "beyond", beyond_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
